// ===== design/integer_matrix_multiply_macros.svh =====
// Assertion macros for the checker of integer_matrix_multiply.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define IMM_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Consequent required in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/imm_pkg.sv =====
// Package for integer_matrix_multiply: field widths, op and register codes,
// sequencer states and the issue record passed from sequencer to MAC.
// No dependencies.
package imm_pkg;

  localparam int DIM_W      = 4;   // dimension registers
  localparam int IDX_W      = 3;   // row / column fields
  localparam int IN_ELEM_W  = 16;  // element field
  localparam int ENTRY_W    = 35;  // product entry field
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_ROWS  = 2'd0,
    CFG_LEFT_COLS  = 2'd1,
    CFG_RIGHT_ROWS = 2'd2,
    CFG_RIGHT_COLS = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_RUN,
    S_ERR
  } seq_state_e;

  typedef struct packed {
    logic [DIM_W-1:0] left_rows;
    logic [DIM_W-1:0] left_cols;
    logic [DIM_W-1:0] right_rows;
    logic [DIM_W-1:0] right_cols;
  } cfg_t;

  typedef struct packed {
    logic             rd;          // read pair issued this cycle
    logic             first;       // first inner step of an entry
    logic             lastk;       // final inner step of an entry
    logic             last_entry;  // final entry of the run
    logic             post_err;    // load the dimension error result
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } issue_t;

endpackage

// ===== design/imm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/imm_seq.sv =====
// Sequencer: walks rows, columns and the inner index, issues read pairs
// to both element RAMs and posts the dimension error. Uses imm_pkg.
module imm_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imm_pkg::cfg_t        cfg_i,
  input  logic                 start_i,
  input  logic                 pipe_busy_i,
  input  logic                 out_free_i,
  output logic                 idle_o,
  output imm_pkg::issue_t      issue_o,
  output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] left_raddr_o,
  output logic [(MAX_DIM * MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] right_raddr_o
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int DW     = imm_pkg::DIM_W;
  localparam int IW     = imm_pkg::IDX_W;

  imm_pkg::seq_state_e state_q, state_d;
  logic [CNT_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic dims_ok, lastk, last_col, last_entry, can_go;

  function automatic logic dim_ok(input logic [DW-1:0] d);
    return d != '0 && d <= DW'(MAX_DIM);
  endfunction

  assign dims_ok = dim_ok(cfg_i.left_rows) && dim_ok(cfg_i.left_cols) &&
                   dim_ok(cfg_i.right_rows) && dim_ok(cfg_i.right_cols) &&
                   cfg_i.left_cols == cfg_i.right_rows;
  assign lastk      = (DW'(k_q) + DW'(1)) == cfg_i.left_cols;
  assign last_col   = (DW'(c_q) + DW'(1)) == cfg_i.right_cols;
  assign last_entry = last_col && ((DW'(r_q) + DW'(1)) == cfg_i.left_rows);
  assign can_go     = !pipe_busy_i && out_free_i;

  assign left_raddr_o  = ADDR_W'(int'(r_q) * MAX_DIM + int'(k_q));
  assign right_raddr_o = ADDR_W'(int'(k_q) * MAX_DIM + int'(c_q));
  assign idle_o        = state_q == imm_pkg::S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imm_pkg::S_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    k_d     = k_q;
    issue_o = '0;
    issue_o.row = IW'(r_q);
    issue_o.col = IW'(c_q);
    case (state_q)
      imm_pkg::S_IDLE: begin
        if (start_i) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = dims_ok ? imm_pkg::S_WAIT : imm_pkg::S_ERR;
        end
      end
      imm_pkg::S_WAIT: begin
        if (can_go) begin
          k_d     = '0;
          state_d = imm_pkg::S_RUN;
        end
      end
      imm_pkg::S_RUN: begin
        issue_o.rd         = 1'b1;
        issue_o.first      = k_q == '0;
        issue_o.lastk      = lastk;
        issue_o.last_entry = last_entry;
        if (lastk) begin
          if (last_entry) begin
            state_d = imm_pkg::S_IDLE;
          end else begin
            state_d = imm_pkg::S_WAIT;
            if (last_col) begin
              c_d = '0;
              r_d = r_q + CNT_W'(1);
            end else begin
              c_d = c_q + CNT_W'(1);
            end
          end
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end
      imm_pkg::S_ERR: begin
        if (can_go) begin
          issue_o.post_err = 1'b1;
          state_d          = imm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = imm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/imm_mac.sv =====
// Multiply-accumulate datapath: RAM read stage, registered multiply,
// accumulator and the output register. Uses imm_pkg.
module imm_mac #(
  parameter int ELEM_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  imm_pkg::issue_t               issue_i,
  input  logic [ELEM_BITS-1:0]          left_rdata_i,
  input  logic [ELEM_BITS-1:0]          right_rdata_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [imm_pkg::IDX_W-1:0]     out_row_o,
  output logic [imm_pkg::IDX_W-1:0]     out_col_o,
  output logic [imm_pkg::ENTRY_W-1:0]   out_entry_o,
  output logic                          out_last_o,
  output logic                          out_err_o,
  output logic                          pipe_busy_o
);

  localparam int EW     = imm_pkg::ENTRY_W;
  localparam int PROD_W = 2 * ELEM_BITS;

  logic                     s1_valid_q, s2_valid_q, out_valid_q;
  imm_pkg::issue_t          s1_info_q, s2_info_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [EW-1:0]            acc_q, acc_d;
  logic                     load_entry;

  assign acc_d       = s2_info_q.first ? EW'(prod_q) : acc_q + EW'(prod_q);
  assign load_entry  = s2_valid_q && s2_info_q.lastk;
  assign pipe_busy_o = s1_valid_q || s2_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue_i.rd;
      s2_valid_q <= s1_valid_q;
      if (load_entry || issue_i.post_err) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_info_q <= issue_i;
    s2_info_q <= s1_info_q;
    if (s1_valid_q) begin
      prod_q <= $signed(left_rdata_i) * $signed(right_rdata_i);
    end
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (load_entry) begin
      out_row_o   <= s2_info_q.row;
      out_col_o   <= s2_info_q.col;
      out_entry_o <= acc_d;
      out_last_o  <= s2_info_q.last_entry;
      out_err_o   <= 1'b0;
    end else if (issue_i.post_err) begin
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_entry_o <= '0;
      out_last_o  <= 1'b1;
      out_err_o   <= 1'b1;
    end
  end

endmodule

// ===== design/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier: configuration registers,
// input decode, element RAMs. Uses imm_pkg, imm_ram, imm_seq, imm_mac.
//
//  Channel  Dir  Handshake              Payload
//  s_axis   in   tvalid/tready          tuser op; tdata row, col, element
//  m_axis   out  tvalid/tready          tdata row, col, entry; tlast; tuser error
//  cfg      in   cfg_we_i (no wait)     cfg_idx_i, cfg_data_i
//
// Ready is high whenever the sequencer is idle; a compute holds ready low. Bad or
// mismatched dimensions post one error. Each product entry issues left_cols read
// pairs to the RAM ports, then passes the RAM read register, the multiply register
// and the accumulator; the next waits for an empty pipeline and a free output.
// Reset sets all dimensions to 1; the element RAMs are not cleared.
// m_axis_tready low holds the output register and stalls the sequencer.
module integer_matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [imm_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [imm_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // row_index, col_index, element
  input  logic [imm_pkg::OP_W-1:0]          s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [imm_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // out_row, out_col, product_entry
  output logic                              m_axis_tlast,  // last
  output logic                              m_axis_tuser   // dim_error
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int DW     = imm_pkg::DIM_W;
  localparam int IW     = imm_pkg::IDX_W;
  localparam int EW     = imm_pkg::ENTRY_W;
  localparam int PAD_W  = imm_pkg::M_TDATA_W - 2 * IW - EW;

  imm_pkg::cfg_t    cfg_q;
  imm_pkg::issue_t  issue;
  logic             accept, idle, start, wr_left, wr_right, pipe_busy;
  logic [IW-1:0]    in_row, in_col, out_row, out_col;
  logic signed [imm_pkg::IN_ELEM_W-1:0] in_elem;
  logic [ELEM_BITS-1:0] wdata, left_rdata, right_rdata;
  logic [ADDR_W-1:0] waddr, left_raddr, right_raddr;
  logic [EW-1:0]    out_entry;
  logic             in_range_left, in_range_right;

  assign in_row  = s_axis_tdata[IW-1:0];
  assign in_col  = s_axis_tdata[2*IW-1:IW];
  assign in_elem = s_axis_tdata[2*IW+imm_pkg::IN_ELEM_W-1:2*IW];
  assign wdata   = ELEM_BITS'(in_elem);
  assign waddr   = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_range_left  = DW'(in_row) < cfg_q.left_rows && DW'(in_col) < cfg_q.left_cols &&
                          DW'(in_row) < DW'(MAX_DIM) && DW'(in_col) < DW'(MAX_DIM);
  assign in_range_right = DW'(in_row) < cfg_q.right_rows && DW'(in_col) < cfg_q.right_cols &&
                          DW'(in_row) < DW'(MAX_DIM) && DW'(in_col) < DW'(MAX_DIM);

  always_comb begin
    wr_left  = 1'b0;
    wr_right = 1'b0;
    start    = 1'b0;
    case (imm_pkg::op_e'(s_axis_tuser))
      imm_pkg::OP_WR_LEFT:  wr_left  = accept && in_range_left;
      imm_pkg::OP_WR_RIGHT: wr_right = accept && in_range_right;
      imm_pkg::OP_COMPUTE:  start    = accept;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_rows  <= DW'(1);
      cfg_q.left_cols  <= DW'(1);
      cfg_q.right_rows <= DW'(1);
      cfg_q.right_cols <= DW'(1);
    end else if (cfg_we_i) begin
      case (imm_pkg::cfg_idx_e'(cfg_idx_i))
        imm_pkg::CFG_LEFT_ROWS:  cfg_q.left_rows  <= cfg_data_i;
        imm_pkg::CFG_LEFT_COLS:  cfg_q.left_cols  <= cfg_data_i;
        imm_pkg::CFG_RIGHT_ROWS: cfg_q.right_rows <= cfg_data_i;
        imm_pkg::CFG_RIGHT_COLS: cfg_q.right_cols <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (wr_left),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue.rd),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  imm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (wr_right),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue.rd),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  imm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .start_i       (start),
    .pipe_busy_i   (pipe_busy),
    .out_free_i    (!m_axis_tvalid || m_axis_tready),
    .idle_o        (idle),
    .issue_o       (issue),
    .left_raddr_o  (left_raddr),
    .right_raddr_o (right_raddr)
  );

  imm_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .left_rdata_i  (left_rdata),
    .right_rdata_i (right_rdata),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_entry_o   (out_entry),
    .out_last_o    (m_axis_tlast),
    .out_err_o     (m_axis_tuser),
    .pipe_busy_o   (pipe_busy)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_entry, out_col, out_row};

endmodule

// ===== design/imm_checker.sv =====
// Port-level checker for integer_matrix_multiply, bound to the top level.
// Uses imm_pkg and integer_matrix_multiply_macros.svh.
`include "integer_matrix_multiply_macros.svh"

module imm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [imm_pkg::DIM_W-1:0]     cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [imm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [imm_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [imm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic                          m_axis_tuser
);

  `IMM_ASSERT(err_is_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "error transfer without tlast")
  `IMM_ASSERT(err_data_zero, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0, "error transfer carries data")
  `IMM_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
  `IMM_ASSERT_NEXT(busy_after_compute, s_axis_tvalid && s_axis_tready && s_axis_tuser == imm_pkg::OP_COMPUTE, !s_axis_tready, "input ready right after a compute transfer")

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
